// ===== rtl/tcce_pkg.sv =====
// shared types and constants for the text console cursor engine
// depends on nothing; imported by every module of the block
package tcce_pkg;

  localparam int unsigned DEF_SCREEN_ROWS = 25;
  localparam int unsigned DEF_SCREEN_COLS = 80;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned ROWS_W      = 3;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned TDATA_W     = 48;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_MAX = 8'h7F;
  localparam logic [CHAR_W-1:0] CHAR_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_VT        = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_FF        = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;

  localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h07;
  localparam logic              NL_RETURN_RESET = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_CURSOR = 2'd3
  } cmd_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEXT_ATTRIBUTE      = 1'b0,
    REG_NEWLINE_ADDS_RETURN = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_IGNORE    = 3'd0,
    OP_PRINT     = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_TAB       = 3'd3,
    OP_LINE_FEED = 3'd4,
    OP_VTAB      = 3'd5,
    OP_FORM_FEED = 3'd6,
    OP_RETURN    = 3'd7
  } op_kind_e;

  typedef struct packed {
    op_kind_e            kind;
    logic [CHAR_W-1:0]   char_code;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // command is the lowest field
  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [ROWS_W-1:0] scroll_rows;
    logic [DATA_W-1:0] cell_data;
    logic [ADDR_W-1:0] cell_address;
    cmd_e              command;
  } beat_t;

  localparam int unsigned BEAT_W = $bits(beat_t);

endpackage

// ===== rtl/tcce_front.sv =====
// front end: takes character beats and classifies them into operations
// depends on tcce_pkg
module tcce_front (
  input  logic                       s_axis_tvalid_i,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code_i,
  input  tcce_pkg::queue_stat_t      q_stat_i,
  output logic                       s_axis_tready_o,
  output logic                       push_o,
  output tcce_pkg::op_t              op_o
);
  import tcce_pkg::*;

  op_kind_e kind;

  always_comb begin
    if (char_code_i inside {[CHAR_SPACE:CHAR_PRINT_MAX]}) begin
      kind = OP_PRINT;
    end else begin
      case (char_code_i)
        CHAR_BS:  kind = OP_BACKSPACE;
        CHAR_TAB: kind = OP_TAB;
        CHAR_LF:  kind = OP_LINE_FEED;
        CHAR_VT:  kind = OP_VTAB;
        CHAR_FF:  kind = OP_FORM_FEED;
        CHAR_CR:  kind = OP_RETURN;
        default:  kind = OP_IGNORE;
      endcase
    end
  end

  // ignored bytes are taken and dropped here
  assign s_axis_tready_o = !q_stat_i.full;
  assign push_o          = s_axis_tvalid_i && !q_stat_i.full && (kind != OP_IGNORE);
  assign op_o.kind       = kind;
  assign op_o.char_code  = char_code_i;

endmodule

// ===== rtl/tcce_queue.sv =====
// short operation queue between front and back end
// depends on tcce_pkg
module tcce_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tcce_pkg::op_t         push_op_i,
  input  logic                  pop_i,
  output tcce_pkg::op_t         pop_op_o,
  output tcce_pkg::queue_stat_t stat_o
);
  import tcce_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign pop_op_o     = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/tcce_back.sv =====
// back end: cursor state, command sequencer and output register
// depends on tcce_pkg
module tcce_back #(
  parameter int unsigned SCREEN_ROWS = tcce_pkg::DEF_SCREEN_ROWS,
  parameter int unsigned SCREEN_COLS = tcce_pkg::DEF_SCREEN_COLS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        op_valid_i,
  input  tcce_pkg::op_t               op_i,
  output logic                        op_pop_o,
  input  logic [tcce_pkg::ATTR_W-1:0] attr_i,
  input  logic                        nl_return_i,
  output logic                        beat_valid_o,
  output tcce_pkg::beat_t             beat_o,
  output logic                        beat_last_o,
  input  logic                        beat_ready_i
);
  import tcce_pkg::*;

  localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
  localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
  localparam int unsigned CELL_W = $clog2(SCREEN_ROWS * SCREEN_COLS);

  typedef enum logic [3:0] {
    PH_LEAD   = 4'b0001,
    PH_SCROLL = 4'b0010,
    PH_MOVE   = 4'b0100,
    PH_TAIL   = 4'b1000
  } phase_e;

  phase_e            phase_q, phase_d, ph_eff, ph_next;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CELL_W-1:0] cell_q, cell_d;

  // advance of the cursor for tab, printable, line feed and vertical tab
  logic [COL_W:0]    col_step, col_sum;
  logic              col_wrap;
  logic [COL_W-1:0]  adv_col;
  logic [2:0]        row_inc;
  logic [ROW_W:0]    row_sum;
  logic              row_over;
  logic [ROW_W-1:0]  adv_row;
  logic [ROWS_W-1:0] adv_scroll;

  logic              emit, done, last, upd, act, out_free;
  cmd_e              cmd;
  beat_t             beat;
  logic              out_valid_q;
  beat_t             out_beat_q;
  logic              out_last_q;

  logic [CELL_W+ADDR_W-1:0] cell_q_ext, cell_d_ext;

  always_comb begin
    case (op_i.kind)
      OP_PRINT: col_step = (COL_W+1)'(1);
      OP_TAB:   col_step = (COL_W+1)'(4);
      default:  col_step = '0;
    endcase
    col_sum  = {1'b0, col_q} + col_step;
    col_wrap = (col_sum >= (COL_W+1)'(SCREEN_COLS));
    adv_col  = col_wrap ? COL_W'(col_sum - (COL_W+1)'(SCREEN_COLS)) : COL_W'(col_sum);
    case (op_i.kind)
      OP_LINE_FEED: row_inc = 3'd1;
      OP_VTAB:      row_inc = 3'd4;
      default:      row_inc = {2'b00, col_wrap};
    endcase
    row_sum  = {1'b0, row_q} + (ROW_W+1)'(row_inc);
    row_over = (row_sum >= (ROW_W+1)'(SCREEN_ROWS));
    adv_row  = row_over ? ROW_W'(SCREEN_ROWS - 1) : ROW_W'(row_sum);
    adv_scroll = row_over ? ROWS_W'(row_sum - (ROW_W+1)'(SCREEN_ROWS - 1)) : '0;
  end

  // sequencer: one command per cycle unless the output register is stalled, cursor moves on each set-cursor
  always_comb begin
    ph_eff  = phase_q;
    ph_next = phase_q;
    emit    = 1'b0;
    done    = 1'b0;
    last    = 1'b0;
    upd     = 1'b0;
    cmd     = CMD_WRITE;
    row_d   = row_q;
    col_d   = col_q;
    // operations with nothing to do before the move start at the scroll step
    if (phase_q == PH_LEAD && (op_i.kind == OP_TAB || op_i.kind == OP_VTAB ||
        (op_i.kind == OP_LINE_FEED && !nl_return_i))) begin
      ph_eff = PH_SCROLL;
    end
    case (ph_eff)
      PH_LEAD: begin
        case (op_i.kind)
          OP_PRINT: begin
            emit    = 1'b1;
            cmd     = CMD_WRITE;
            ph_next = PH_SCROLL;
          end
          OP_BACKSPACE: begin
            if (col_q == '0) begin
              done = 1'b1;
            end else begin
              emit    = 1'b1;
              cmd     = CMD_CURSOR;
              upd     = 1'b1;
              col_d   = col_q - COL_W'(1);
              ph_next = PH_TAIL;
            end
          end
          OP_LINE_FEED, OP_RETURN: begin
            emit  = 1'b1;
            cmd   = CMD_CURSOR;
            upd   = 1'b1;
            col_d = '0;
            if (op_i.kind == OP_RETURN) begin
              done = 1'b1;
              last = 1'b1;
            end else begin
              ph_next = PH_SCROLL;
            end
          end
          OP_FORM_FEED: begin
            emit    = 1'b1;
            cmd     = CMD_CLEAR;
            ph_next = PH_TAIL;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      PH_SCROLL: begin
        emit = 1'b1;
        if (adv_scroll != '0) begin
          cmd     = CMD_SCROLL;
          ph_next = PH_MOVE;
        end else begin
          cmd   = CMD_CURSOR;
          upd   = 1'b1;
          row_d = adv_row;
          col_d = adv_col;
          done  = 1'b1;
          last  = 1'b1;
        end
      end
      PH_MOVE: begin
        emit  = 1'b1;
        cmd   = CMD_CURSOR;
        upd   = 1'b1;
        row_d = adv_row;
        col_d = adv_col;
        done  = 1'b1;
        last  = 1'b1;
      end
      PH_TAIL: begin
        emit = 1'b1;
        done = 1'b1;
        last = 1'b1;
        if (op_i.kind == OP_BACKSPACE) begin
          cmd = CMD_WRITE;
        end else begin
          cmd   = CMD_CURSOR;
          upd   = 1'b1;
          row_d = '0;
          col_d = '0;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign cell_d = CELL_W'(row_d) * CELL_W'(SCREEN_COLS) + CELL_W'(col_d);

  assign cell_q_ext = {{ADDR_W{1'b0}}, cell_q};
  assign cell_d_ext = {{ADDR_W{1'b0}}, cell_d};

  always_comb begin
    beat         = '0;
    beat.command = cmd;
    case (cmd)
      CMD_WRITE: begin
        beat.cell_address = cell_q_ext[ADDR_W-1:0];
        beat.cell_data    = {attr_i, (op_i.kind == OP_PRINT) ? op_i.char_code : CHAR_SPACE};
      end
      CMD_SCROLL: begin
        beat.cell_data   = {attr_i, CHAR_SPACE};
        beat.scroll_rows = adv_scroll;
      end
      CMD_CLEAR: begin
        beat.cell_data = {attr_i, CHAR_SPACE};
      end
      CMD_CURSOR: begin
        beat.cursor_position = cell_d_ext[ADDR_W-1:0];
      end
      default: begin
        beat.cell_data = '0;
      end
    endcase
  end

  assign out_free = !out_valid_q || beat_ready_i;
  assign act      = op_valid_i && (!emit || out_free);
  assign op_pop_o = act && done;
  assign phase_d  = done ? PH_LEAD : ph_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      row_q       <= '0;
      col_q       <= '0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (act) begin
        phase_q <= phase_d;
        if (upd) begin
          row_q  <= row_d;
          col_q  <= col_d;
          cell_q <= cell_d;
        end
      end
      if (act && emit) begin
        out_valid_q <= 1'b1;
      end else if (beat_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act && emit) begin
      out_beat_q <= beat;
      out_last_q <= last;
    end
  end

  assign beat_valid_o = out_valid_q;
  assign beat_o       = out_beat_q;
  assign beat_last_o  = out_last_q;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// text console cursor engine: an accepted character passes the operation queue and the output register
// before its first command beat leaves; the back end issues one command per cycle unless the output is
// stalled, zero to three per item (none for a backspace in column zero); ignored bytes are dropped at the front
// throughput is set by the single command sequencer behind a 2-entry operation queue
// async active-low reset: cursor at top left, attribute 0x07, line feed returns, queue empty
module text_console_cursor_engine #(
  parameter int unsigned SCREEN_ROWS = tcce_pkg::DEF_SCREEN_ROWS,
  parameter int unsigned SCREEN_COLS = tcce_pkg::DEF_SCREEN_COLS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // character stream in
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,   // [7:0] char_code
  // command stream out
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] command, [12:2] cell_address, [28:13] cell_data, [31:29] scroll_rows,
  // [42:32] cursor_position, [47:43] zero
  output logic [tcce_pkg::TDATA_W-1:0]     m_axis_tdata_o,
  output logic                             m_axis_tlast_o,   // last command of a character
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tcce_pkg::*;

  // configuration registers; the user must write them only while the engine is idle, the block does not enforce it
  logic [ATTR_W-1:0] attr_q;
  logic              nl_return_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      nl_return_q <= NL_RETURN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEXT_ATTRIBUTE:      attr_q      <= cfg_data_i[ATTR_W-1:0];
        REG_NEWLINE_ADDS_RETURN: nl_return_q <= cfg_data_i[0];
        default:                 attr_q      <= attr_q;
      endcase
    end
  end

  // front end classifies and pushes real operations only
  queue_stat_t q_stat;
  logic        q_push, q_pop;
  op_t         push_op, pop_op;

  tcce_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .char_code_i     (s_axis_tdata_i[CHAR_W-1:0]),
    .q_stat_i        (q_stat),
    .s_axis_tready_o (s_axis_tready_o),
    .push_o          (q_push),
    .op_o            (push_op)
  );

  // decouples classification from the command sequencer
  tcce_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .pop_i     (q_pop),
    .pop_op_o  (pop_op),
    .stat_o    (q_stat)
  );

  // back end owns the cursor and the output register
  beat_t beat;

  tcce_back #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (!q_stat.empty),
    .op_i         (pop_op),
    .op_pop_o     (q_pop),
    .attr_i       (attr_q),
    .nl_return_i  (nl_return_q),
    .beat_valid_o (m_axis_tvalid_o),
    .beat_o       (beat),
    .beat_last_o  (m_axis_tlast_o),
    .beat_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {{(TDATA_W - BEAT_W){1'b0}}, beat};

  // no push into a full queue: front must see backpressure
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("operation pushed into full queue");

  // back end only pops when an operation is present
  a_pop_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("operation popped from empty queue");

  // a scroll covers one to four rows
  a_scroll_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && beat.command == CMD_SCROLL) |->
      (beat.scroll_rows != '0 && beat.scroll_rows <= 3'd4))
    else $error("scroll beat with bad row count");

  // only set-cursor beats carry a cursor position
  a_pos_only_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && beat.command != CMD_CURSOR) |-> (beat.cursor_position == '0))
    else $error("cursor position on a non-cursor beat");

endmodule

// ===== dv/testbench.sv =====
// self-checking bench for the text console cursor engine: directed table, then random text
// needs tcce_pkg, text_console_cursor_engine and its submodules from rtl; nothing else is read
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int unsigned SCREEN_ROWS  = DEF_SCREEN_ROWS;
  localparam int unsigned SCREEN_COLS  = DEF_SCREEN_COLS;
  localparam int unsigned CELL_COUNT   = SCREEN_ROWS * SCREEN_COLS;
  localparam int unsigned DIRECTED_N   = 25;
  localparam int unsigned PHASE_CHARS  = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_MAX    = 20;

  // one command as it should leave the block
  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] cell_address;
    logic [DATA_W-1:0] cell_data;
    logic [ROWS_W-1:0] scroll_rows;
    logic [ADDR_W-1:0] cursor_position;
    logic              last;
  } console_cmd_t;

  // a directed row; pinned rows carry commands typed in by hand
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              pinned;
    logic [1:0]        pinned_n;
    console_cmd_t      first;
    console_cmd_t      second;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [7:0]             s_axis_tdata_i;   // [7:0] char_code
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // [1:0] command, [12:2] cell_address, [28:13] cell_data, [31:29] scroll_rows,
  // [42:32] cursor_position, [47:43] zero
  logic [TDATA_W-1:0]     m_axis_tdata_o;
  logic                   m_axis_tlast_o;   // last command of a character
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  text_console_cursor_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor state, mirrors the block's registers and cursor
  logic [ATTR_W-1:0] console_attr = ATTR_RESET;
  logic              lf_returns   = NL_RETURN_RESET;
  int unsigned       cursor_at    = 0;

  console_cmd_t step_cmds[$];      // commands of the character just predicted
  console_cmd_t pending_cmds[$];   // commands still owed by the block, oldest first
  int unsigned  handled_chars      = 0;
  int unsigned  mismatch_count     = 0;
  int unsigned  sender_idle_pct    = 0;
  int unsigned  receiver_stall_pct = 0;
  bit           long_hold_req      = 1'b0;
  int unsigned  cycle_count        = 0;

  // directed rows: reset registers, attribute 0x07, line feed returns
  stim_row_t directed_tbl [DIRECTED_N] = '{
    // backspace in column zero does nothing
    '{CHAR_BS, 1'b1, 2'd0, '0, '0},
    '{8'h41, 1'b1, 2'd2, '{CMD_WRITE, 11'd0, 16'h0741, 3'd0, 11'd0, 1'b0},
                         '{CMD_CURSOR, 11'd0, 16'h0000, 3'd0, 11'd1, 1'b1}},
    // backspace steps back then blanks the cell
    '{CHAR_BS, 1'b1, 2'd2, '{CMD_CURSOR, 11'd0, 16'h0000, 3'd0, 11'd0, 1'b0},
                           '{CMD_WRITE, 11'd0, 16'h0720, 3'd0, 11'd0, 1'b1}},
    '{CHAR_PRINT_MAX, 1'b1, 2'd2, '{CMD_WRITE, 11'd0, 16'h077F, 3'd0, 11'd0, 1'b0},
                                  '{CMD_CURSOR, 11'd0, 16'h0000, 3'd0, 11'd1, 1'b1}},
    '{CHAR_SPACE, 1'b1, 2'd2, '{CMD_WRITE, 11'd1, 16'h0720, 3'd0, 11'd0, 1'b0},
                              '{CMD_CURSOR, 11'd0, 16'h0000, 3'd0, 11'd2, 1'b1}},
    '{CHAR_TAB, 1'b0, 2'd0, '0, '0},
    '{CHAR_CR, 1'b0, 2'd0, '0, '0},
    // ignored bytes, low and high controls and the top half
    '{8'h00, 1'b1, 2'd0, '0, '0},
    '{8'h0E, 1'b1, 2'd0, '0, '0},
    '{8'h1F, 1'b1, 2'd0, '0, '0},
    '{8'h80, 1'b1, 2'd0, '0, '0},
    '{8'hFF, 1'b1, 2'd0, '0, '0},
    '{CHAR_LF, 1'b0, 2'd0, '0, '0},
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_FF, 1'b1, 2'd2, '{CMD_CLEAR, 11'd0, 16'h0720, 3'd0, 11'd0, 1'b0},
                           '{CMD_CURSOR, 11'd0, 16'h0000, 3'd0, 11'd0, 1'b1}},
    // walk down to row 20 by vertical tabs
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_LF, 1'b0, 2'd0, '0, '0},
    // vertical tab past the bottom: one row, then all four rows
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    '{CHAR_VT, 1'b0, 2'd0, '0, '0},
    // line feed on the bottom row scrolls one
    '{CHAR_LF, 1'b0, 2'd0, '0, '0},
    '{CHAR_FF, 1'b0, 2'd0, '0, '0}
  };

  function automatic void push_cmd(input cmd_e cmd, input int unsigned addr,
                                   input logic [DATA_W-1:0] data, input int unsigned rows,
                                   input int unsigned pos);
    console_cmd_t c;
    c.command         = cmd;
    c.cell_address    = addr[ADDR_W-1:0];
    c.cell_data       = data;
    c.scroll_rows     = rows[ROWS_W-1:0];
    c.cursor_position = pos[ADDR_W-1:0];
    c.last            = 1'b0;
    step_cmds.push_back(c);
  endfunction

  // move forward, scrolling whole rows while the cursor is past the last cell
  function automatic void move_forward(input int unsigned delta);
    int unsigned pos;
    int unsigned rows;
    pos  = cursor_at + delta;
    rows = 0;
    while (pos >= CELL_COUNT && rows < 8) begin
      pos  = pos - SCREEN_COLS;
      rows = rows + 1;
    end
    if (rows != 0) push_cmd(CMD_SCROLL, 0, {console_attr, CHAR_SPACE}, rows, 0);
    cursor_at = pos;
    push_cmd(CMD_CURSOR, 0, '0, 0, cursor_at);
  endfunction

  // commands one character causes; updates the cursor
  function automatic void predict_commands(input logic [CHAR_W-1:0] ch);
    int unsigned col;
    bit          known;
    col   = cursor_at % SCREEN_COLS;
    known = 1'b1;
    step_cmds.delete();
    if (ch >= CHAR_SPACE && ch <= CHAR_PRINT_MAX) begin
      push_cmd(CMD_WRITE, cursor_at, {console_attr, ch}, 0, 0);
      move_forward(1);
    end else begin
      case (ch)
        CHAR_BS: begin
          if (col != 0) begin
            cursor_at = cursor_at - 1;
            push_cmd(CMD_CURSOR, 0, '0, 0, cursor_at);
            push_cmd(CMD_WRITE, cursor_at, {console_attr, CHAR_SPACE}, 0, 0);
          end
        end
        CHAR_TAB: move_forward(4);
        CHAR_LF: begin
          if (lf_returns) begin
            cursor_at = cursor_at - col;
            push_cmd(CMD_CURSOR, 0, '0, 0, cursor_at);
          end
          move_forward(SCREEN_COLS);
        end
        CHAR_VT: move_forward(4 * SCREEN_COLS);
        CHAR_FF: begin
          push_cmd(CMD_CLEAR, 0, {console_attr, CHAR_SPACE}, 0, 0);
          cursor_at = 0;
          push_cmd(CMD_CURSOR, 0, '0, 0, 0);
        end
        CHAR_CR: begin
          cursor_at = cursor_at - col;
          push_cmd(CMD_CURSOR, 0, '0, 0, cursor_at);
        end
        default: known = 1'b0;
      endcase
    end
    if (step_cmds.size() != 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
    if (known) handled_chars = handled_chars + 1;
  endfunction

  // offer one character, wait for its beat, then book the commands it owes
  task automatic send_char(input stim_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= row.char_code;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_commands(row.char_code);
    if (row.pinned) begin
      if (row.pinned_n > 0) pending_cmds.push_back(row.first);
      if (row.pinned_n > 1) pending_cmds.push_back(row.second);
    end else begin
      foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    end
  endtask

  task automatic send_plain(input logic [CHAR_W-1:0] ch);
    stim_row_t row;
    row           = '0;
    row.char_code = ch;
    send_char(row);
  endtask

  // mostly lines of text ending in a newline, some cursor moves, some noise
  task automatic run_random(input int unsigned budget);
    int unsigned goal;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    logic [CHAR_W-1:0] ch;
    goal = handled_chars + budget;
    while (handled_chars < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // short lines, or long ones that wrap and may run off the screen end
        len = $urandom_range(1) ? $urandom_range(1, 16) : $urandom_range(40, 85);
        for (k = 0; k < len && handled_chars < goal; k++) begin
          pick = $urandom_range(99);
          if (pick < 8) ch = CHAR_TAB;
          else if (pick < 14) ch = CHAR_BS;
          else ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_PRINT_MAX));
          send_plain(ch);
        end
        if ($urandom_range(3) == 0) send_plain(CHAR_CR);
        send_plain(CHAR_LF);
      end else if (pick < 68) begin
        // head for the bottom rows
        repeat ($urandom_range(1, 7)) send_plain($urandom_range(1) ? CHAR_VT : CHAR_LF);
      end else if (pick < 78) begin
        send_plain($urandom_range(1) ? CHAR_CR : CHAR_BS);
      end else if (pick < 96) begin
        send_plain(CHAR_W'($urandom_range(255)));
      end else begin
        send_plain(CHAR_FF);
      end
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  // wait out every owed command, then the block's own tail
  task automatic drain_commands();
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, only while the block is idle
  task automatic program_regs(input logic [ATTR_W-1:0] attr, input logic nl);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TEXT_ATTRIBUTE;
    cfg_data_i  <= attr;
    @(posedge clk_i);
    // upper bits are don't care for the one-bit register
    cfg_index_i <= REG_NEWLINE_ADDS_RETURN;
    cfg_data_i  <= {7'($urandom_range(127)), nl};
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    console_attr = attr;
    lf_returns   = nl;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit, counts every cycle from the start
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count = cycle_count + 1;
    end
    $display("** text_console_cursor_engine: FAILED **");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // checker: each command beat against the oldest owed command
  initial begin : command_checker
    beat_t        got;
    console_cmd_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[BEAT_W-1:0];
        if (pending_cmds.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("%0t: unexpected beat cmd=%0d addr=%0d data=%h rows=%0d pos=%0d last=%b",
                     $time, got.command, got.cell_address, got.cell_data, got.scroll_rows,
                     got.cursor_position, m_axis_tlast_o);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = pending_cmds.pop_front();
          if (got.command !== want.command || got.cell_address !== want.cell_address ||
              got.cell_data !== want.cell_data || got.scroll_rows !== want.scroll_rows ||
              got.cursor_position !== want.cursor_position || m_axis_tlast_o !== want.last ||
              m_axis_tdata_o[TDATA_W-1:BEAT_W] !== '0) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("%0t: expected cmd=%0d addr=%0d data=%h rows=%0d pos=%0d last=%b",
                       $time, want.command, want.cell_address, want.cell_data,
                       want.scroll_rows, want.cursor_position, want.last);
              $display("%0t: actual   cmd=%0d addr=%0d data=%h rows=%0d pos=%0d last=%b pad=%h",
                       $time, got.command, got.cell_address, got.cell_data, got.scroll_rows,
                       got.cursor_position, m_axis_tlast_o, m_axis_tdata_o[TDATA_W-1:BEAT_W]);
            end
            mismatch_count = mismatch_count + 1;
          end
        end
      end
    end
  end

  // stimulus: reset, directed table, then phases of random text
  initial begin : stimulus
    int unsigned i;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_TEXT_ATTRIBUTE;
    cfg_data_i      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows run on the reset register values
    for (i = 0; i < DIRECTED_N; i++) send_char(directed_tbl[i]);
    s_axis_tvalid_i <= 1'b0;
    drain_commands();

    // full attribute, line feed without return, no idling
    program_regs(8'hFF, 1'b0);
    run_random(PHASE_CHARS);
    drain_commands();

    // zero attribute, sender mostly idle
    program_regs(8'h00, 1'b1);
    sender_idle_pct = 81;
    run_random(PHASE_CHARS);
    drain_commands();

    // receiver mostly stalled
    program_regs(ATTR_W'($urandom_range(255)), 1'b0);
    sender_idle_pct    = 0;
    receiver_stall_pct = 81;
    run_random(PHASE_CHARS);
    drain_commands();

    // light idling on both sides
    program_regs(ATTR_W'($urandom_range(255)), 1'b1);
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    run_random(PHASE_CHARS);
    drain_commands();

    // long receiver hold-off while characters keep coming, so input backs up
    program_regs(ATTR_W'($urandom_range(255)), 1'($urandom_range(1)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    long_hold_req      = 1'b1;
    run_random(PHASE_CHARS);
    drain_commands();

    if (mismatch_count == 0) begin
      $display("** text_console_cursor_engine: PASSED **");
    end else begin
      $display("** text_console_cursor_engine: FAILED **");
    end
    $finish;
  end

endmodule
